// ----- src/smadd_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants for the sparse matrix add block
// no dependencies; imported by smadd_alu and sparse_matrix_add

package smadd_pkg;

    // default sizing of the stores and fields
    localparam int CAPACITY_DEF   = 32;
    localparam int COORD_BITS_DEF = 16;
    localparam int VALUE_BITS_DEF = 32;

    // fixed port widths
    localparam int MODE_W     = 2;
    localparam int COORD_W    = 16;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 3;

    typedef enum logic [MODE_W-1:0] {
        MODE_INS_A = 2'd0,
        MODE_INS_B = 2'd1,
        MODE_SUM   = 2'd2,
        MODE_CLEAR = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 3'd0,
        STAT_FULL  = 3'd1,
        STAT_DUP   = 3'd2,
        STAT_ENTRY = 3'd3,
        STAT_EMPTY = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SRCH,
        ST_SHIFT,
        ST_SUM,
        ST_FIN,
        ST_RESP
    } t_state;

    // flags from the shared compare / add unit
    typedef struct packed {
        logic lt;
        logic eq;
        logic zero;
    } t_cmp_flags;

endpackage

// ----- src/smadd_ram.sv -----
`timescale 1ns / 1ps
// generic simple dual-port ram, one write and one registered read port
// no dependencies

module smadd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/smadd_alu.sv -----
`timescale 1ns / 1ps
// shared key compare and value add unit
// depends on smadd_pkg

module smadd_alu #(
    parameter int KEY_W = 32,
    parameter int VAL_W = 32
) (
    input  logic [KEY_W-1:0]         i_key_x,
    input  logic [KEY_W-1:0]         i_key_y,
    input  logic [VAL_W-1:0]         i_val_x,
    input  logic [VAL_W-1:0]         i_val_y,
    output logic [VAL_W-1:0]         o_sum,
    output smadd_pkg::t_cmp_flags    o_flags
);
    import smadd_pkg::*;

    logic [VAL_W-1:0] sum;

    // wraparound add, carry out dropped
    assign sum = i_val_x + i_val_y;

    always_comb begin
        o_flags.lt   = i_key_x < i_key_y;
        o_flags.eq   = i_key_x == i_key_y;
        o_flags.zero = sum == '0;
    end

    assign o_sum = sum;

endmodule

// ----- src/sparse_matrix_add.sv -----
`timescale 1ns / 1ps
// sparse matrix add top level: sequencer, two coordinate-list stores, output register
// depends on smadd_pkg, smadd_ram, smadd_alu

// Holds two sparse matrices A and B as coordinate lists of up to CAPACITY
// entries each, kept sorted by {row, col}. A request with mode 0 or 1 inserts
// an entry into A or B and answers one result: accepted, store full or
// duplicate coordinate. Mode 2 merges both lists and emits the sum entries in
// row-major order with status "sum entry" (equal coordinates add with
// wraparound, zero sums dropped), or one "sum empty" result; the final result
// of every request carries last. Mode 3 empties both stores. One request is
// in work at a time and o_ready is low meanwhile; results leave through an
// output register, so a request can be taken while the previous answer still
// waits. An insert is a linear search of the store at one entry per cycle,
// then a shift of the entries above the insert point at one entry per cycle
// through the store's single write port. A full store answers without a
// search. A sum makes one merge step per cycle through the shared compare /
// add unit while the output side does not stall. No clearing pass is needed
// after reset.

module sparse_matrix_add #(
    parameter int CAPACITY   = smadd_pkg::CAPACITY_DEF,
    parameter int COORD_BITS = smadd_pkg::COORD_BITS_DEF,
    parameter int VALUE_BITS = smadd_pkg::VALUE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request channel
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [smadd_pkg::MODE_W-1:0]        i_mode,
    input  logic [smadd_pkg::COORD_W-1:0]       i_entry_row,
    input  logic [smadd_pkg::COORD_W-1:0]       i_entry_col,
    input  logic signed [smadd_pkg::VALUE_W-1:0] i_entry_value,
    // result channel
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [smadd_pkg::STATUS_W-1:0]      o_status,
    output logic [smadd_pkg::COORD_W-1:0]       o_out_row,
    output logic [smadd_pkg::COORD_W-1:0]       o_out_col,
    output logic signed [smadd_pkg::VALUE_W-1:0] o_out_value,
    output logic                                o_last
);
    import smadd_pkg::*;

    localparam int KEY_W  = 2 * COORD_BITS;
    localparam int WORD_W = KEY_W + VALUE_BITS;
    localparam int AW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    // sequencer state
    t_state                  r_state, n_state;
    t_mode                   r_mode;
    t_status                 r_rsp, n_rsp;
    logic [CNT_W-1:0]        r_cnt_a, n_cnt_a;
    logic [CNT_W-1:0]        r_cnt_b, n_cnt_b;
    logic [CNT_W-1:0]        r_idx, n_idx;     // walks A, or the insert target
    logic [CNT_W-1:0]        r_jdx, n_jdx;     // walks B during a sum
    logic [CNT_W-1:0]        r_pos, n_pos;     // insert position

    // latched request payload
    logic [KEY_W-1:0]        r_key;
    logic [VALUE_BITS-1:0]   r_val;

    // held-back sum entry, so the final one can be marked last
    logic                    r_pend_v, n_pend_v;
    logic [KEY_W-1:0]        r_pend_key, n_pend_key;
    logic [VALUE_BITS-1:0]   r_pend_val, n_pend_val;

    // output register
    logic                    r_ov, n_ov;
    t_status                 r_ost, n_ost;
    logic [KEY_W-1:0]        r_okey, n_okey;
    logic [VALUE_BITS-1:0]   r_oval, n_oval;
    logic                    r_olast, n_olast;

    // store ports
    logic                    we_a, we_b;
    logic [AW-1:0]           waddr;
    logic [WORD_W-1:0]       wdata;
    logic [CNT_W-1:0]        rd_a, rd_b;
    logic [WORD_W-1:0]       rdata_a, rdata_b;

    // shared unit
    logic [KEY_W-1:0]        cmp_x;
    logic [VALUE_BITS-1:0]   alu_sum;
    t_cmp_flags              flags;

    logic                    in_acc;
    logic                    out_free;
    logic                    is_b;
    logic [CNT_W-1:0]        cnt_sel;
    logic [WORD_W-1:0]       rdata_sel;

    // merge step decode
    logic                    a_ok, b_ok;
    logic                    take_a, take_b;
    logic                    cand_v;
    logic [KEY_W-1:0]        cand_key;
    logic [VALUE_BITS-1:0]   cand_val;

    assign in_acc    = i_valid && o_ready;
    assign out_free  = !r_ov || i_ready;
    assign is_b      = (r_mode == MODE_INS_B);
    assign cnt_sel   = is_b ? r_cnt_b : r_cnt_a;
    assign rdata_sel = is_b ? rdata_b : rdata_a;

    smadd_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CAPACITY)
    ) u_store_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (rd_a[AW-1:0]),
        .o_rdata (rdata_a)
    );

    smadd_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CAPACITY)
    ) u_store_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (rd_b[AW-1:0]),
        .o_rdata (rdata_b)
    );

    // search compares the target entry with the new key, a sum compares A with B
    assign cmp_x = (r_mode == MODE_SUM) ? rdata_a[WORD_W-1:VALUE_BITS]
                                        : rdata_sel[WORD_W-1:VALUE_BITS];

    smadd_alu #(
        .KEY_W (KEY_W),
        .VAL_W (VALUE_BITS)
    ) u_alu (
        .i_key_x (cmp_x),
        .i_key_y ((r_mode == MODE_SUM) ? rdata_b[WORD_W-1:VALUE_BITS] : r_key),
        .i_val_x (rdata_a[VALUE_BITS-1:0]),
        .i_val_y (rdata_b[VALUE_BITS-1:0]),
        .o_sum   (alu_sum),
        .o_flags (flags)
    );

    // merge step: which side(s) the current step consumes
    always_comb begin
        a_ok     = r_idx < r_cnt_a;
        b_ok     = r_jdx < r_cnt_b;
        take_a   = a_ok && (!b_ok || flags.lt || flags.eq);
        take_b   = b_ok && (!a_ok || !flags.lt);
        cand_key = take_a ? rdata_a[WORD_W-1:VALUE_BITS] : rdata_b[WORD_W-1:VALUE_BITS];
        if (take_a && take_b) begin
            cand_val = alu_sum;
        end else if (take_a) begin
            cand_val = rdata_a[VALUE_BITS-1:0];
        end else begin
            cand_val = rdata_b[VALUE_BITS-1:0];
        end
        // matching coordinates that cancel produce nothing
        cand_v = !(take_a && take_b && flags.zero);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt_a  <= '0;
            r_cnt_b  <= '0;
            r_pend_v <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt_a  <= n_cnt_a;
            r_cnt_b  <= n_cnt_b;
            r_pend_v <= n_pend_v;
            r_ov     <= n_ov;
        end
    end

    // payload and working registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_jdx      <= n_jdx;
        r_pos      <= n_pos;
        r_rsp      <= n_rsp;
        r_pend_key <= n_pend_key;
        r_pend_val <= n_pend_val;
        r_ost      <= n_ost;
        r_okey     <= n_okey;
        r_oval     <= n_oval;
        r_olast    <= n_olast;
        if (in_acc) begin
            r_mode <= t_mode'(i_mode);
            r_key  <= {i_entry_row[COORD_BITS-1:0], i_entry_col[COORD_BITS-1:0]};
            r_val  <= i_entry_value[VALUE_BITS-1:0];
        end
    end

    always_comb begin
        n_state    = r_state;
        n_rsp      = r_rsp;
        n_cnt_a    = r_cnt_a;
        n_cnt_b    = r_cnt_b;
        n_idx      = r_idx;
        n_jdx      = r_jdx;
        n_pos      = r_pos;
        n_pend_v   = r_pend_v;
        n_pend_key = r_pend_key;
        n_pend_val = r_pend_val;
        n_ost      = r_ost;
        n_okey     = r_okey;
        n_oval     = r_oval;
        n_olast    = r_olast;
        n_ov       = r_ov && !i_ready;
        rd_a       = r_idx;
        rd_b       = r_idx;
        we_a       = 1'b0;
        we_b       = 1'b0;
        waddr      = r_idx[AW-1:0];
        wdata      = rdata_sel;

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_idx = '0;
                    n_jdx = '0;
                    rd_a  = '0;
                    rd_b  = '0;
                    unique case (t_mode'(i_mode))
                        MODE_INS_A: begin
                            if (r_cnt_a == CNT_W'(CAPACITY)) begin
                                n_rsp   = STAT_FULL;
                                n_state = ST_RESP;
                            end else begin
                                n_state = ST_SRCH;
                            end
                        end
                        MODE_INS_B: begin
                            if (r_cnt_b == CNT_W'(CAPACITY)) begin
                                n_rsp   = STAT_FULL;
                                n_state = ST_RESP;
                            end else begin
                                n_state = ST_SRCH;
                            end
                        end
                        MODE_SUM: begin
                            n_pend_v = 1'b0;
                            n_state  = ST_SUM;
                        end
                        MODE_CLEAR: begin
                            n_cnt_a = '0;
                            n_cnt_b = '0;
                            n_rsp   = STAT_OK;
                            n_state = ST_RESP;
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end

            // linear scan for the first entry not below the new key
            ST_SRCH: begin
                if (r_idx >= cnt_sel || !flags.lt) begin
                    if (r_idx < cnt_sel && flags.eq) begin
                        n_rsp   = STAT_DUP;
                        n_state = ST_RESP;
                    end else begin
                        n_pos   = r_idx;
                        n_idx   = cnt_sel;
                        rd_a    = cnt_sel - 1'b1;
                        rd_b    = cnt_sel - 1'b1;
                        n_state = ST_SHIFT;
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                    rd_a  = r_idx + 1'b1;
                    rd_b  = r_idx + 1'b1;
                end
            end

            // move entries up one slot from the top down, then drop in the new one
            ST_SHIFT: begin
                we_a = !is_b;
                we_b = is_b;
                if (r_idx == r_pos) begin
                    wdata = {r_key, r_val};
                    if (is_b) begin
                        n_cnt_b = r_cnt_b + 1'b1;
                    end else begin
                        n_cnt_a = r_cnt_a + 1'b1;
                    end
                    n_rsp   = STAT_OK;
                    n_state = ST_RESP;
                end else begin
                    n_idx = r_idx - 1'b1;
                    rd_a  = r_idx - CNT_W'(2);
                    rd_b  = r_idx - CNT_W'(2);
                end
            end

            // one merge step per cycle unless a pending entry cannot leave
            ST_SUM: begin
                rd_a = r_idx;
                rd_b = r_jdx;
                if (!a_ok && !b_ok) begin
                    n_state = ST_FIN;
                end else if (!(cand_v && r_pend_v && !out_free)) begin
                    n_idx = r_idx + CNT_W'(take_a);
                    n_jdx = r_jdx + CNT_W'(take_b);
                    rd_a  = r_idx + CNT_W'(take_a);
                    rd_b  = r_jdx + CNT_W'(take_b);
                    if (cand_v) begin
                        if (r_pend_v) begin
                            n_ov    = 1'b1;
                            n_ost   = STAT_ENTRY;
                            n_okey  = r_pend_key;
                            n_oval  = r_pend_val;
                            n_olast = 1'b0;
                        end
                        n_pend_v   = 1'b1;
                        n_pend_key = cand_key;
                        n_pend_val = cand_val;
                    end
                end
            end

            // flush the held entry as last, or report an empty sum
            ST_FIN: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_olast = 1'b1;
                    if (r_pend_v) begin
                        n_ost  = STAT_ENTRY;
                        n_okey = r_pend_key;
                        n_oval = r_pend_val;
                    end else begin
                        n_ost  = STAT_EMPTY;
                        n_okey = '0;
                        n_oval = '0;
                    end
                    n_pend_v = 1'b0;
                    n_state  = ST_IDLE;
                end
            end

            ST_RESP: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_ost   = r_rsp;
                    n_okey  = '0;
                    n_oval  = '0;
                    n_olast = 1'b1;
                    n_state = ST_IDLE;
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

    assign o_ready     = (r_state == ST_IDLE);
    assign o_valid     = r_ov;
    assign o_status    = r_ost;
    assign o_out_row   = COORD_W'(r_okey[KEY_W-1:COORD_BITS]);
    assign o_out_col   = COORD_W'(r_okey[COORD_BITS-1:0]);
    assign o_out_value = VALUE_W'(signed'(r_oval));
    assign o_last      = r_olast;

    // entry counts never pass the store size
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt_a <= CNT_W'(CAPACITY)) && (r_cnt_b <= CNT_W'(CAPACITY)))
        else $error("entry count beyond capacity");

    // a clear request empties both stores
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_mode == MODE_CLEAR) |=> (r_cnt_a == '0 && r_cnt_b == '0))
        else $error("clear did not empty the stores");

    // counts only grow at the end of a shift pass
    a_cnt_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_SHIFT) |=> (r_cnt_a <= $past(r_cnt_a) && r_cnt_b <= $past(r_cnt_b)))
        else $error("entry count grew outside an insert");

    // a held sum entry exists only while a sum is in work
    a_pend_scope: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_v |-> (r_state == ST_SUM || r_state == ST_FIN))
        else $error("pending sum entry outside a sum");

endmodule
